FILE: src/sop_pkg.sv
// ----------------------------------------------------------------------------
// sop_pkg: shared types and constants of the solver output parser
// Character codes, line modes, status and error codes, status word table.
// ----------------------------------------------------------------------------
package sop_pkg;

  localparam int unsigned SOP_MAX_VARIABLES = 65536;
  localparam logic [16:0] SOP_VAR_COUNT_RST = 17'h10000;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_UC_S  = 8'h53;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_V  = 8'h76;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_COST    = 3'd2,
    MODE_STATUS  = 3'd3,
    MODE_VALUES  = 3'd4
  } mode_t;

  localparam logic [1:0] STAT_UNKNOWN = 2'd0;
  localparam logic [1:0] STAT_SAT     = 2'd1;
  localparam logic [1:0] STAT_UNSAT   = 2'd2;
  localparam logic [1:0] STAT_OPTIMUM = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LINE_KIND = 3'd1;
  localparam logic [2:0] ERR_NUMBER    = 3'd2;
  localparam logic [2:0] ERR_STATUS    = 3'd3;
  localparam logic [2:0] ERR_VALUE_CH  = 3'd4;
  localparam logic [2:0] ERR_VAR_RANGE = 3'd5;

  localparam int NUM_WORDS = 4;

  // Status words, left aligned in 16 characters, zero padded
  localparam logic [127:0] WORD_TEXT [NUM_WORDS] = '{
    {"UNKNOWN",       {9{8'h00}}},
    {"UNSATISFIABLE", {3{8'h00}}},
    {"SATISFIABLE",   {5{8'h00}}},
    {"OPTIMUM FOUND", {3{8'h00}}}
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{4'd7, 4'd13, 4'd11, 4'd13};
  localparam logic [1:0] WORD_STATUS [NUM_WORDS] = '{
    STAT_UNKNOWN, STAT_UNSAT, STAT_SAT, STAT_OPTIMUM
  };

  // Parser state carried from byte to byte
  typedef struct packed {
    mode_t       mode;
    logic [31:0] acc;
    logic        neg;
    logic        digit_seen;
    logic [3:0]  mask;
    logic [3:0]  pos;
    logic        space_seen;
    logic [1:0]  status;
    logic [31:0] cost;
    logic [2:0]  err;
  } parse_state_t;

  // Word matcher results
  typedef struct packed {
    logic [3:0] mask_nxt;
    logic       hit;
    logic [1:0] hit_status;
  } match_t;

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [3:0] p);
    logic [127:0] txt;
    txt = WORD_TEXT[w];
    return txt[8*(15 - int'(p)) +: 8];
  endfunction

endpackage

FILE: src/sop_if.sv
// ----------------------------------------------------------------------------
// sop_if: request channels of the solver output parser
// Input byte, result and configuration channels, valid/ready.
// ----------------------------------------------------------------------------
interface sop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface sop_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status_code;
  logic signed [31:0] cost_value;
  logic               assign_valid;
  logic [16:0]        assign_variable;
  logic               assign_polarity;
  logic [2:0]         error_code;
  modport source (output valid, output status_code, output cost_value,
                  output assign_valid, output assign_variable,
                  output assign_polarity, output error_code, input ready);
  modport sink   (input valid, input status_code, input cost_value,
                  input assign_valid, input assign_variable,
                  input assign_polarity, input error_code, output ready);
endinterface

interface sop_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] variable_count;
  modport source (output valid, output variable_count, input ready);
  modport sink   (input valid, input variable_count, output ready);
endinterface

FILE: src/sat_solver_output_parser.sv
// ----------------------------------------------------------------------------
// sat_solver_output_parser: solver output text parser
// Path: byte request to result through the input register and the result
//   register; one result per byte.
// Throughput: one byte per cycle while the result channel is ready.
// Reset: synchronous active-low rst_n; parser state, variable_count (65536)
//   and channel valids cleared, no warm-up pass.
// ----------------------------------------------------------------------------
module sat_solver_output_parser
  import sop_pkg::*;
#(
  parameter int unsigned MAX_VARIABLES = SOP_MAX_VARIABLES
) (
  input  logic      clk,
  input  logic      rst_n,
  sop_in_if.sink    in_chan,
  sop_out_if.source out_chan,
  sop_cfg_if.sink   cfg_chan
);

  // Input register
  logic [7:0]  byte_r;
  logic        in_vld_r;
  // Result register
  logic        out_vld_r;
  logic [1:0]  status_r;
  logic [31:0] cost_r;
  logic        ev_valid_r;
  logic [16:0] ev_var_r;
  logic        ev_pos_r;
  logic [2:0]  err_r;
  // Parser state and config
  parse_state_t st_r, st_nxt;
  logic [16:0]  var_count_r;

  logic        advance;
  logic        ev_valid;
  logic [16:0] ev_var;
  logic        ev_pos;

  // The byte moves into the result register when that register is free or
  // is being emptied; the input register refills in the same cycle.
  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign cfg_chan.ready = 1'b1;

  sop_step #(
    .MAX_VARIABLES (MAX_VARIABLES)
  ) u_step (
    .ch        (byte_r),
    .st        (st_r),
    .var_count (var_count_r),
    .st_nxt    (st_nxt),
    .ev_valid  (ev_valid),
    .ev_var    (ev_var),
    .ev_pos    (ev_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      var_count_r    <= SOP_VAR_COUNT_RST;
      st_r.mode      <= MODE_BETWEEN;
      st_r.acc       <= '0;
      st_r.neg       <= 1'b0;
      st_r.digit_seen <= 1'b0;
      st_r.mask      <= 4'hF;
      st_r.pos       <= '0;
      st_r.space_seen <= 1'b0;
      st_r.status    <= STAT_UNKNOWN;
      st_r.cost      <= 32'hFFFF_FFFF;
      st_r.err       <= ERR_NONE;
    end else begin
      if (cfg_chan.valid) var_count_r <= cfg_chan.variable_count;

      if (in_chan.ready) in_vld_r <= in_chan.valid;

      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) byte_r <= in_chan.text_byte;
    if (advance) begin
      status_r   <= st_nxt.status;
      cost_r     <= st_nxt.cost;
      ev_valid_r <= ev_valid;
      ev_var_r   <= ev_var;
      ev_pos_r   <= ev_pos;
      err_r      <= st_nxt.err;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.status_code     = status_r;
  assign out_chan.cost_value      = signed'(cost_r);
  assign out_chan.assign_valid    = ev_valid_r;
  assign out_chan.assign_variable = ev_var_r;
  assign out_chan.assign_polarity = ev_pos_r;
  assign out_chan.error_code      = err_r;

endmodule

FILE: src/sop_word_match.sv
// ----------------------------------------------------------------------------
// sop_word_match: status word matcher
// Narrows the candidate mask by one character and flags a complete word.
// ----------------------------------------------------------------------------
module sop_word_match
  import sop_pkg::*;
(
  input  logic [7:0] ch,
  input  logic [3:0] mask,
  input  logic [3:0] pos,
  output match_t     match
);

  always_comb begin
    match = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      match.mask_nxt[i] = mask[i] && (pos < WORD_LEN[i]) && (word_char(2'(i), pos) == ch);
    end
    // first complete candidate wins
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (mask[i] && WORD_LEN[i] == pos) begin
        match.hit        = 1'b1;
        match.hit_status = WORD_STATUS[i];
      end
    end
  end

endmodule

FILE: src/sop_step.sv
// ----------------------------------------------------------------------------
// sop_step: per-byte parser update
// Next state and assignment event for one byte of solver output.
// ----------------------------------------------------------------------------
module sop_step
  import sop_pkg::*;
#(
  parameter int unsigned MAX_VARIABLES = SOP_MAX_VARIABLES
) (
  input  logic [7:0]   ch,
  input  parse_state_t st,
  input  logic [16:0]  var_count,
  output parse_state_t st_nxt,
  output logic         ev_valid,
  output logic [16:0]  ev_var,
  output logic         ev_pos
);

  localparam logic [31:0] VarCap = 32'(MAX_VARIABLES);

  logic        is_digit, is_upper, is_blank, is_ws;
  logic [35:0] acc_sum;
  logic [31:0] acc_add;
  logic [31:0] limit;
  logic        lit_over;
  logic        lit_ok;
  logic        run_between;
  match_t      match;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_upper = (ch >= CH_UC_A) && (ch <= CH_UC_Z);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_ws    = is_blank || (ch == CH_LF);

  // acc * 10 + digit, saturating at all ones
  assign acc_sum = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {32'd0, ch[3:0]};
  assign acc_add = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];

  assign limit    = ({15'd0, var_count} < VarCap) ? {15'd0, var_count} : VarCap;
  assign lit_over = st.neg ? (st.acc[31] && (st.acc[30:0] != 31'd0)) : st.acc[31];

  sop_word_match u_match (
    .ch    (ch),
    .mask  (st.mask),
    .pos   (st.pos),
    .match (match)
  );

  always_comb begin
    st_nxt      = st;
    ev_valid    = 1'b0;
    ev_var      = '0;
    ev_pos      = 1'b0;
    run_between = 1'b0;
    lit_ok      = 1'b1;
    if (st.err == ERR_NONE) begin
      case (st.mode)
        MODE_COMMENT: begin
          if (ch == CH_LF) st_nxt.mode = MODE_BETWEEN;
        end
        MODE_COST: begin
          if (is_digit) begin
            st_nxt.acc        = acc_add;
            st_nxt.digit_seen = 1'b1;
          end else if (!st.digit_seen && is_blank) begin
            st_nxt = st;
          end else if (!st.digit_seen || st.acc[31]) begin
            st_nxt.err = ERR_NUMBER;
          end else begin
            st_nxt.cost = st.acc;
            if (st.status == STAT_UNKNOWN) st_nxt.status = STAT_SAT;
            run_between = 1'b1;
          end
        end
        MODE_STATUS: begin
          if (st.pos == 4'd0 && is_blank) begin
            st_nxt = st;
          end else if (is_upper || (ch == CH_SPACE && !st.space_seen)) begin
            if (!is_upper) st_nxt.space_seen = 1'b1;
            st_nxt.mask = match.mask_nxt;
            st_nxt.pos  = (st.pos == 4'hF) ? st.pos : st.pos + 4'd1;
          end else if (match.hit) begin
            st_nxt.status = match.hit_status;
            if ((match.hit_status == STAT_SAT || match.hit_status == STAT_OPTIMUM)
                && st.cost[31]) begin
              st_nxt.cost = '0;
            end
            run_between = 1'b1;
          end else begin
            st_nxt.err = ERR_STATUS;
          end
        end
        MODE_VALUES: begin
          if (is_digit) begin
            st_nxt.acc        = acc_add;
            st_nxt.digit_seen = 1'b1;
          end else begin
            // close the pending literal, if any
            if (st.neg || st.digit_seen) begin
              if (!st.digit_seen || lit_over) begin
                st_nxt.err = ERR_NUMBER;
                lit_ok     = 1'b0;
              end else begin
                st_nxt.acc        = '0;
                st_nxt.neg        = 1'b0;
                st_nxt.digit_seen = 1'b0;
                if (st.acc != 32'd0) begin
                  if (st.acc > limit) begin
                    st_nxt.err = ERR_VAR_RANGE;
                    lit_ok     = 1'b0;
                  end else begin
                    ev_valid = 1'b1;
                    ev_var   = st.acc[16:0];
                    ev_pos   = !st.neg;
                  end
                end
              end
            end
            if (lit_ok) begin
              if (ch == CH_MINUS) begin
                st_nxt.neg = 1'b1;
              end else if (ch == CH_LF) begin
                st_nxt.mode = MODE_BETWEEN;
              end else if (!is_blank) begin
                st_nxt.err = ERR_VALUE_CH;
              end
            end
          end
        end
        default: run_between = 1'b1;
      endcase
    end

    // line kind selection; also re-handles the byte that ended a token
    if (run_between) begin
      st_nxt.mode = MODE_BETWEEN;
      if (!is_ws) begin
        st_nxt.acc        = '0;
        st_nxt.neg        = 1'b0;
        st_nxt.digit_seen = 1'b0;
        if (ch == CH_LC_C) begin
          st_nxt.mode = MODE_COMMENT;
        end else if (ch == CH_LC_O) begin
          st_nxt.mode = MODE_COST;
        end else if (ch == CH_LC_S || ch == CH_UC_S) begin
          st_nxt.mode       = MODE_STATUS;
          st_nxt.mask       = 4'hF;
          st_nxt.pos        = '0;
          st_nxt.space_seen = 1'b0;
        end else if (ch == CH_LC_V) begin
          st_nxt.mode = MODE_VALUES;
        end else begin
          st_nxt.err = ERR_LINE_KIND;
        end
      end
    end
  end

endmodule

FILE: verif/sat_solver_output_parser_tb.sv
// ----------------------------------------------------------------------------
// sat_solver_output_parser_tb: self-checking bench for the solver output parser
// Streams solver text into the parser one byte per request. Directed lines come
// first, then random well-formed lines under several variable counts. The run
// ends with one randomly chosen error, after which the outputs must hold. A
// local model of the parser predicts every result, and each field is compared.
// ----------------------------------------------------------------------------
module sat_solver_output_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sop_pkg::*;

  // Index into the status word table
  localparam int W_UNKNOWN = 0;
  localparam int W_UNSAT   = 1;
  localparam int W_SAT     = 2;
  localparam int W_OPTIMUM = 3;

  localparam logic [7:0] CH_LC_X = 8'h78;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] cost;
    logic        assign_valid;
    logic [16:0] var_num;
    logic        polarity;
    logic [2:0]  err;
  } parse_result_t;

  string      word_txt  [NUM_WORDS] = '{"UNKNOWN", "UNSATISFIABLE", "SATISFIABLE",
                                        "OPTIMUM FOUND"};
  logic [1:0] word_code [NUM_WORDS] = '{STAT_UNKNOWN, STAT_UNSAT, STAT_SAT, STAT_OPTIMUM};

  logic clk = 1'b0;
  logic rst_n;

  sop_in_if  in_if ();
  sop_out_if out_if ();
  sop_cfg_if cfg_if ();

  sat_solver_output_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  parse_result_t expected_q [$];   // one entry per accepted byte, oldest first
  int  fail_count = 0;
  int  bytes_sent = 0;
  int  var_limit  = SOP_MAX_VARIABLES; // literal limit the stimulus keeps to
  int  stall_left = 0;
  bit  no_idle    = 1'b0;             // set: neither side inserts gaps

  // --------------------------------------------------------------------------
  // Parser model: a private copy of the parse state, stepped once per
  // accepted byte by the monitor below.
  // --------------------------------------------------------------------------
  mode_t       p_mode;
  logic [31:0] p_acc;
  logic        p_neg;
  logic        p_digit;
  logic [3:0]  p_mask;     // status words still possible
  logic [3:0]  p_pos;      // letters of the status word seen so far
  logic        p_space;    // the one inner space of a status word is used
  logic [1:0]  p_status;
  logic [31:0] p_cost;
  logic [2:0]  p_err;
  logic [16:0] p_var_count;
  logic        e_valid;
  logic [16:0] e_var;
  logic        e_pos;

  function automatic void reset_model();
    p_mode      = MODE_BETWEEN;
    p_acc       = '0;
    p_neg       = 1'b0;
    p_digit     = 1'b0;
    p_mask      = 4'hF;
    p_pos       = '0;
    p_space     = 1'b0;
    p_status    = STAT_UNKNOWN;
    p_cost      = '1;
    p_err       = ERR_NONE;
    p_var_count = SOP_VAR_COUNT_RST;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_TAB;
  endfunction

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic void clear_number();
    p_acc   = '0;
    p_neg   = 1'b0;
    p_digit = 1'b0;
  endfunction

  // Decimal accumulate, pinned at all ones on overflow
  function automatic void push_digit(input logic [7:0] ch);
    longint unsigned t;
    t = 64'(p_acc) * 10 + 64'(ch - CH_ZERO);
    p_acc   = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    p_digit = 1'b1;
  endfunction

  // First byte of a line picks its kind; whitespace keeps us between lines
  function automatic void start_line(input logic [7:0] ch);
    p_mode = MODE_BETWEEN;
    if (is_blank(ch) || ch == CH_LF) return;
    clear_number();
    if (ch == CH_LC_C) begin
      p_mode = MODE_COMMENT;
    end else if (ch == CH_LC_O) begin
      p_mode = MODE_COST;
    end else if (ch == CH_LC_S || ch == CH_UC_S) begin
      p_mode  = MODE_STATUS;
      p_mask  = 4'hF;
      p_pos   = '0;
      p_space = 1'b0;
    end else if (ch == CH_LC_V) begin
      p_mode = MODE_VALUES;
    end else begin
      p_err = ERR_LINE_KIND;
    end
  endfunction

  function automatic void cost_char(input logic [7:0] ch);
    if (is_digit(ch)) begin
      push_digit(ch);
      return;
    end
    if (!p_digit && is_blank(ch)) return;
    if (!p_digit || p_acc > 32'h7FFF_FFFF) begin
      p_err = ERR_NUMBER;
      return;
    end
    p_cost = p_acc;
    if (p_status == STAT_UNKNOWN) p_status = STAT_SAT;
    start_line(ch);
  endfunction

  function automatic void step_word(input logic [7:0] ch);
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (p_mask[i] && (p_pos >= word_txt[i].len() || word_txt[i][p_pos] != ch))
        p_mask[i] = 1'b0;
    end
    if (p_pos < 4'd15) p_pos = p_pos + 4'd1;
  endfunction

  function automatic void status_char(input logic [7:0] ch);
    if (p_pos == 0 && is_blank(ch)) return;
    if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
      step_word(ch);
      return;
    end
    if (ch == CH_SPACE && !p_space) begin
      p_space = 1'b1;
      step_word(ch);
      return;
    end
    // Any other byte closes the word; it has to be complete
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (p_mask[i] && word_txt[i].len() == p_pos) begin
        p_status = word_code[i];
        if ((p_status == STAT_SAT || p_status == STAT_OPTIMUM) && p_cost[31])
          p_cost = '0;
        start_line(ch);
        return;
      end
    end
    p_err = ERR_STATUS;
  endfunction

  // Closes a pending literal; returns 0 when that latched an error
  function automatic bit end_literal();
    logic [31:0] mag_max;
    logic [31:0] mag;
    logic [31:0] limit;
    logic        was_neg;
    if (!p_neg && !p_digit) return 1'b1;
    mag_max = p_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (!p_digit || p_acc > mag_max) begin
      p_err = ERR_NUMBER;
      return 1'b0;
    end
    mag     = p_acc;
    was_neg = p_neg;
    clear_number();
    if (mag == 0) return 1'b1;
    limit = (32'(p_var_count) < SOP_MAX_VARIABLES) ? 32'(p_var_count) : SOP_MAX_VARIABLES;
    if (mag > limit) begin
      p_err = ERR_VAR_RANGE;
      return 1'b0;
    end
    e_valid = 1'b1;
    e_var   = mag[16:0];
    e_pos   = !was_neg;
    return 1'b1;
  endfunction

  function automatic void value_char(input logic [7:0] ch);
    if (is_digit(ch)) begin
      push_digit(ch);
      return;
    end
    if (!end_literal()) return;
    if (ch == CH_MINUS) begin
      p_neg = 1'b1;
    end else if (ch == CH_LF) begin
      p_mode = MODE_BETWEEN;
    end else if (!is_blank(ch)) begin
      p_err = ERR_VALUE_CH;
    end
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] ch);
    parse_result_t r;
    e_valid = 1'b0;
    e_var   = '0;
    e_pos   = 1'b0;
    // A latched error freezes everything
    if (p_err == ERR_NONE) begin
      case (p_mode)
        MODE_COMMENT: begin
          if (ch == CH_LF) p_mode = MODE_BETWEEN;
        end
        MODE_COST:   cost_char(ch);
        MODE_STATUS: status_char(ch);
        MODE_VALUES: value_char(ch);
        default:     start_line(ch);
      endcase
    end
    r.status       = p_status;
    r.cost         = p_cost;
    r.assign_valid = e_valid;
    r.var_num      = e_var;
    r.polarity     = e_pos;
    r.err          = p_err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks each result request against the oldest prediction, then
  // folds in a config write or an input byte seen at the same edge.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status       = out_if.status_code;
        got.cost         = out_if.cost_value;
        got.assign_valid = out_if.assign_valid;
        got.var_num      = out_if.assign_variable;
        got.polarity     = out_if.assign_polarity;
        got.err          = out_if.error_code;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no byte outstanding, expected none actual %h",
                   $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status_code", want.status, got.status);
          check_field("cost_value", want.cost, got.cost);
          check_field("assign_valid", want.assign_valid, got.assign_valid);
          check_field("assign_variable", want.var_num, got.var_num);
          check_field("assign_polarity", want.polarity, got.polarity);
          check_field("error_code", want.err, got.err);
        end
      end
      if (cfg_if.valid && cfg_if.ready) p_var_count = cfg_if.variable_count;
      if (in_if.valid && in_if.ready) expected_q.push_back(parse_byte(in_if.text_byte));
    end
  end

  // --------------------------------------------------------------------------
  // Back-pressure on the result side: mostly ready, short stalls, the odd
  // long one; none at all while no_idle is set.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle) stall_left = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Sending
  // --------------------------------------------------------------------------
  // One byte request; valid stays up between back-to-back bytes
  task automatic send_byte(input logic [7:0] ch);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= ch;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Decimal digits, now and then with leading zeros
  task automatic send_number(input longint unsigned v);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_byte(CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  task automatic send_blanks(input int lo, input int hi, input bit with_lf);
    int r;
    repeat ($urandom_range(lo, hi)) begin
      r = $urandom_range(0, with_lf ? 2 : 1);
      send_byte(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_LF));
    end
  endtask

  // Lowers valid and waits until every byte has its result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_var_count(input logic [16:0] n);
    wait_drained();
    repeat (3) @(posedge clk);  // pipeline settles past its two stages
    cfg_if.valid          <= 1'b1;
    cfg_if.variable_count <= n;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    var_limit = (n < SOP_MAX_VARIABLES) ? n : SOP_MAX_VARIABLES;
  endtask

  // --------------------------------------------------------------------------
  // Line generators; each leaves the parser between lines
  // --------------------------------------------------------------------------
  task automatic send_comment_line();
    logic [7:0] b;
    send_byte(CH_LC_C);
    repeat ($urandom_range(0, 16)) begin
      b = 8'($urandom_range(0, 254));
      if (b >= CH_LF) b = b + 8'd1;   // anything but newline
      send_byte(b);
    end
    send_byte(CH_LF);
  endtask

  task automatic send_cost_line();
    int r;
    send_byte(CH_LC_O);
    send_blanks(0, 2, 1'b0);
    r = $urandom_range(0, 9);
    if (r == 0)      send_number(0);
    else if (r == 1) send_number(32'h7FFF_FFFF);
    else if (r < 6)  send_number($urandom_range(0, 999));
    else             send_number($urandom() & 32'h7FFF_FFFF);
    // The closing byte is reparsed, so a comment may follow directly
    r = $urandom_range(0, 9);
    if (r < 7)      send_byte(CH_LF);
    else if (r < 9) send_blanks(1, 1, 1'b0);
    else            send_comment_line();
  endtask

  task automatic send_status_line();
    int r;
    send_byte($urandom_range(0, 1) ? CH_LC_S : CH_UC_S);
    send_blanks(0, 2, 1'b0);
    send_text(word_txt[$urandom_range(W_UNKNOWN, W_OPTIMUM)]);
    r = $urandom_range(0, 9);
    if (r < 8)       send_byte(CH_LF);
    else if (r == 8) send_byte(CH_TAB);
    else             send_comment_line();
  endtask

  task automatic send_values_line();
    bit neg;
    int r;
    int mag;
    send_byte(CH_LC_V);
    for (int k = 0; k < $urandom_range(0, 10); k++) begin
      neg = 1'($urandom_range(0, 1));
      // a minus may serve as the separator itself
      if (k == 0 || neg) send_blanks(0, 2, 1'b0);
      else               send_blanks(1, 2, 1'b0);
      if (neg) send_byte(CH_MINUS);
      r = $urandom_range(0, 19);
      if (r < 2)       mag = 0;
      else if (r < 5)  mag = var_limit;
      else if (r < 7)  mag = 1;
      else if (r < 14) mag = $urandom_range(1, (var_limit < 32) ? var_limit : 32);
      else             mag = $urandom_range(1, var_limit);
      send_number(mag);
    end
    send_blanks(0, 1, 1'b0);
    send_byte(CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Whitespace between lines, comment carrying the byte extremes
  task automatic test_line_kinds();
    send_text(" \t\n");
    send_byte(CH_LC_C);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(CH_LF);
  endtask

  // All four words; the first solution word lifts the cost of -1 to 0
  task automatic test_status_words();
    send_text("s UNKNOWN\n");
    if ($urandom_range(0, 1)) send_text("S\tSATISFIABLE\n");
    else                      send_text("sOPTIMUM FOUND\n");
    send_text("s UNSATISFIABLE\t");
    send_text("S OPTIMUM FOUND\n");
  endtask

  // Cost 0 and the largest cost; unknown turns satisfiable; reparsed ender
  task automatic test_cost_lines();
    send_text("s UNKNOWN\n");
    send_text("o0\n");
    send_text("o\t 2147483647c\n");
  endtask

  // Both polarities, the top variable, ignored zeros, minus as separator
  task automatic test_literals();
    send_text("v1 -65536\t-0 0 0012-7\n");
  endtask

  task automatic test_random_text(input int n_bytes);
    int stop_at;
    int r;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_blanks(0, 2, 1'b1);
      r = $urandom_range(0, 99);
      if (r < 40)      send_values_line();
      else if (r < 60) send_cost_line();
      else if (r < 78) send_status_line();
      else             send_comment_line();
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 39) == 0) wait_drained();  // let everything land
    end
    no_idle = 1'b0;
  endtask

  // One error per run (reset comes once), picked at random; the bytes that
  // follow must leave every output frozen
  task automatic test_sticky_error();
    logic [2:0] kind;
    logic [7:0] b;
    kind = 3'($urandom_range(ERR_LINE_KIND, ERR_VAR_RANGE));
    case (kind)
      ERR_LINE_KIND: begin
        if ($urandom_range(0, 3) == 0) begin
          b = 8'h00;
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (is_blank(b) || b == CH_LF || b == CH_LC_C || b == CH_LC_O ||
                 b == CH_LC_S || b == CH_UC_S || b == CH_LC_V);
        end
        send_byte(b);
      end
      ERR_NUMBER: begin
        case ($urandom_range(0, 5))
          0: send_text("o\n");
          1: send_text("o 2147483648\n");
          2: send_text("o 99999999999\n");
          3: send_text("v 4 --1\n");
          4: send_text("v -2147483649\n");
          default: send_text("v -\n");
        endcase
      end
      ERR_STATUS: begin
        case ($urandom_range(0, 5))
          0: send_text("s UNKNOWN \n");
          1: send_text("s\n");
          2: send_text("s SATISFIABL\n");
          3: send_text("S OPTIMUMFOUND\n");
          4: send_text("s unsatisfiable\n");
          default: send_text("s OPTIMUM  FOUND\n");
        endcase
      end
      ERR_VALUE_CH: begin
        // the stray byte also completes the literal in front of it
        send_text("v 1");
        do b = 8'($urandom_range(0, 255));
        while (is_digit(b) || is_blank(b) || b == CH_LF || b == CH_MINUS);
        send_byte($urandom_range(0, 1) ? CH_LC_X : b);
      end
      default: begin
        send_text("v ");
        if ($urandom_range(0, 1)) begin
          send_number(var_limit + 1);
        end else begin
          send_byte(CH_MINUS);
          send_number(32'h8000_0000);
        end
        send_byte(CH_SPACE);
      end
    endcase
    repeat (24) send_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.text_byte       <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.variable_count <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_var_count(SOP_VAR_COUNT_RST);
    test_line_kinds();
    test_status_words();
    test_cost_lines();
    test_literals();

    write_var_count(17'd1);
    test_random_text(300);
    write_var_count(17'($urandom_range(2, 65535)));
    test_random_text(700);
    write_var_count(SOP_VAR_COUNT_RST);
    test_random_text(900);

    write_var_count(17'($urandom_range(1, 65536)));
    test_sticky_error();

    wait_drained();
    repeat (8) @(posedge clk);  // catch any stray result
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
